/* src/swept_sphere_collision_time_top_defines.svh */
// Assertion macros for the swept sphere collision time block.
// Included by the top level; they expand to nothing when SYNTHESIS is defined.
`ifndef SWEPT_SPHERE_COLLISION_TIME_TOP_DEFINES_SVH
`define SWEPT_SPHERE_COLLISION_TIME_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SSCOL_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sscol assertion failed");
`define SSCOL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sscol assertion failed");
`else
`define SSCOL_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define SSCOL_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* src/sscol_pkg.sv */
// Shared constants and types of the swept sphere collision time block.
// No dependencies; used by sscol_sqrt and the top level.
package sscol_pkg;

   localparam int COORD_FRAC_BITS_DEF = 16;
   localparam int TIME_FRAC_BITS_DEF  = 16;

   localparam int COORD_W    = 32;
   localparam int RADIUS_W   = 31;
   localparam int IMPACT_W   = 17;
   localparam int MAG_W      = 66;
   localparam int HALF_W     = 33;
   localparam int REQ_DATA_W = 352;
   localparam int RSP_DATA_W = 24;

   typedef struct packed {
      logic              ok;
      logic [MAG_W-1:0]  h_mag;
      logic [MAG_W-1:0]  a;
   } side_type;

endpackage

/* src/sscol_sqrt.sv */
// Pipelined integer square root, one root bit per register stage.
// Depends on sscol_pkg for the sideband struct carried beside the data.
module sscol_sqrt #(
   parameter int RootW = sscol_pkg::MAG_W + sscol_pkg::TIME_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [2*RootW-1:0]    in_rad,
   input  sscol_pkg::side_type   in_side,
   output logic                  out_valid,
   output logic [RootW-1:0]      out_root,
   output logic                  out_inexact,
   output sscol_pkg::side_type   out_side
);

   logic                        vld_ff  [RootW];
   logic [RootW:0]              rem_ff  [RootW];
   logic [RootW-1:0]            root_ff [RootW];
   logic [2*RootW-1:0]          rad_ff  [RootW];
   sscol_pkg::side_type         side_ff [RootW];

   for (genvar k = 0; k < RootW; k++) begin : g_stage
      logic                     vld_src;
      logic [RootW:0]           rem_src;
      logic [RootW-1:0]         root_src;
      logic [2*RootW-1:0]       rad_src;
      sscol_pkg::side_type      side_src;
      logic [RootW+2:0]         rem_sh;
      logic [RootW+2:0]         trial;
      logic [RootW+2:0]         diff;
      logic                     fits;
      logic [RootW:0]           rem_in;
      logic [RootW-1:0]         root_in;

      if (k == 0) begin : g_first
         assign vld_src  = in_valid;
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = in_rad;
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign rad_src  = rad_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      assign rem_sh  = {rem_src, rad_src[2*RootW-1 -: 2]};
      assign trial   = {1'b0, root_src, 2'b01};
      assign diff    = rem_sh - trial;
      assign fits    = (rem_sh >= trial);
      assign rem_in  = fits ? diff[RootW:0] : rem_sh[RootW:0];
      assign root_in = {root_src[RootW-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= {rad_src[2*RootW-3:0], 2'b00};
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid   = vld_ff[RootW-1];
   assign out_root    = root_ff[RootW-1];
   assign out_inexact = (rem_ff[RootW-1] != '0);
   assign out_side    = side_ff[RootW-1];

endmodule

/* src/swept_sphere_collision_time_top.sv */
// Swept sphere against static sphere: one transaction per clock, fully pipelined.
// The square-root recurrence (one root bit per stage) and the restoring divider
// (one quotient bit per stage) make up most of the pipeline. The pipeline stalls
// as a whole only while a result waits on rsp_tready.
// Depends on sscol_pkg, sscol_sqrt and swept_sphere_collision_time_top_defines.svh.
`include "swept_sphere_collision_time_top_defines.svh"

module swept_sphere_collision_time_top #(
   parameter int COORD_FRAC_BITS = sscol_pkg::COORD_FRAC_BITS_DEF,
   parameter int TIME_FRAC_BITS  = sscol_pkg::TIME_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // prev_x, prev_y, prev_z, cur_x, cur_y, cur_z, other_x, other_y, other_z,
   // mover_radius, other_radius, zero pad
   input  logic [sscol_pkg::REQ_DATA_W-1:0]  req_tdata,
   // prev_valid
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // impact_time, zero pad
   output logic [sscol_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // hit
   output logic                              rsp_tuser
);

   localparam int CW    = sscol_pkg::COORD_W;
   localparam int MW    = sscol_pkg::MAG_W;
   localparam int HW    = sscol_pkg::HALF_W;
   localparam int ImpW  = sscol_pkg::IMPACT_W;
   localparam int RootW = MW + TIME_FRAC_BITS;
   localparam int QuoW  = TIME_FRAC_BITS + 1;
   localparam logic [MW-1:0] ZeroMotion =
      ((66'd1 << (2 * COORD_FRAC_BITS)) + 66'd999999) / 66'd1000000;

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   logic [6:0] pre_vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= '0;
      end else if (adv) begin
         pre_vld_ff <= {pre_vld_ff[5:0], req_tvalid};
      end
   end

   // stage 1: differences
   logic signed [CW:0]   v_in  [3];
   logic signed [CW:0]   r_in  [3];
   logic signed [CW:0]   v_ff  [3];
   logic signed [CW:0]   r_ff  [3];
   logic [CW-1:0]        rs_in;
   logic [CW-1:0]        rs_ff;
   logic                 pv1_ff;

   always_comb begin
      logic [CW-1:0] p;
      logic [CW-1:0] cu;
      logic [CW-1:0] o;
      for (int i = 0; i < 3; i++) begin
         p  = req_tdata[i*CW +: CW];
         cu = req_tdata[(3+i)*CW +: CW];
         o  = req_tdata[(6+i)*CW +: CW];
         v_in[i] = $signed({cu[CW-1], cu}) - $signed({p[CW-1], p});
         r_in[i] = $signed({p[CW-1], p}) - $signed({o[CW-1], o});
      end
      rs_in = {1'b0, req_tdata[9*CW +: sscol_pkg::RADIUS_W]}
            + {1'b0, req_tdata[9*CW+sscol_pkg::RADIUS_W +: sscol_pkg::RADIUS_W]};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v_ff   <= v_in;
         r_ff   <= r_in;
         rs_ff  <= rs_in;
         pv1_ff <= req_tuser;
      end
   end

   // stage 2: products
   logic signed [MW-1:0] vv_in [3];
   logic signed [MW-1:0] rv_in [3];
   logic signed [MW-1:0] rr_in [3];
   logic signed [MW-1:0] vv_ff [3];
   logic signed [MW-1:0] rv_ff [3];
   logic signed [MW-1:0] rr_ff [3];
   logic [2*CW-1:0]      rs2_in;
   logic [2*CW-1:0]      rs2_ff;
   logic                 pv2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vv_in[i] = v_ff[i] * v_ff[i];
         rv_in[i] = r_ff[i] * v_ff[i];
         rr_in[i] = r_ff[i] * r_ff[i];
      end
      rs2_in = rs_ff * rs_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vv_ff  <= vv_in;
         rv_ff  <= rv_in;
         rr_ff  <= rr_in;
         rs2_ff <= rs2_in;
         pv2_ff <= pv1_ff;
      end
   end

   // stage 3: quadratic coefficients
   logic [MW-1:0]        a_in;
   logic signed [MW:0]   h_in;
   logic signed [MW:0]   c_in;
   logic [MW-1:0]        a3_ff;
   logic signed [MW:0]   h3_ff;
   logic signed [MW:0]   c3_ff;
   logic                 pv3_ff;

   assign a_in = $unsigned(vv_ff[0]) + $unsigned(vv_ff[1]) + $unsigned(vv_ff[2]);
   assign h_in = rv_ff[0] + rv_ff[1] + rv_ff[2];
   assign c_in = rr_ff[0] + rr_ff[1] + rr_ff[2] - $signed({3'b000, rs2_ff});

   always_ff @(posedge clock) begin
      if (adv) begin
         a3_ff  <= a_in;
         h3_ff  <= h_in;
         c3_ff  <= c_in;
         pv3_ff <= pv2_ff;
      end
   end

   // stage 4: root range checks and magnitudes
   logic signed [MW+2:0] near_sum;
   logic signed [MW+2:0] far_sum;
   logic                 ok4_in;
   logic [MW:0]          hneg;
   logic                 ok4_ff;
   logic [MW-1:0]        a4_ff;
   logic [MW-1:0]        hm4_ff;
   logic [MW-1:0]        cm4_ff;

   assign near_sum = $signed({3'b000, a3_ff}) + h3_ff;
   assign far_sum  = $signed({3'b000, a3_ff}) + h3_ff + h3_ff + c3_ff;
   assign hneg     = -h3_ff;
   assign ok4_in   = pv3_ff && (a3_ff >= ZeroMotion)
                  && (h3_ff[MW] || (h3_ff == '0)) && !c3_ff[MW]
                  && (!near_sum[MW+2] || far_sum[MW+2] || (far_sum == '0));

   always_ff @(posedge clock) begin
      if (adv) begin
         ok4_ff <= ok4_in;
         a4_ff  <= a3_ff;
         hm4_ff <= hneg[MW-1:0];
         cm4_ff <= c3_ff[MW-1:0];
      end
   end

   // stage 5: partial products of h^2 and a*c
   logic [2*HW-1:0] hh00_ff, hh01_ff, hh11_ff;
   logic [2*HW-1:0] ac00_ff, ac01_ff, ac10_ff, ac11_ff;
   logic            ok5_ff;
   logic [MW-1:0]   a5_ff;
   logic [MW-1:0]   hm5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         hh00_ff <= hm4_ff[HW-1:0] * hm4_ff[HW-1:0];
         hh01_ff <= hm4_ff[HW-1:0] * hm4_ff[MW-1:HW];
         hh11_ff <= hm4_ff[MW-1:HW] * hm4_ff[MW-1:HW];
         ac00_ff <= a4_ff[HW-1:0] * cm4_ff[HW-1:0];
         ac01_ff <= a4_ff[HW-1:0] * cm4_ff[MW-1:HW];
         ac10_ff <= a4_ff[MW-1:HW] * cm4_ff[HW-1:0];
         ac11_ff <= a4_ff[MW-1:HW] * cm4_ff[MW-1:HW];
         ok5_ff  <= ok4_ff;
         a5_ff   <= a4_ff;
         hm5_ff  <= hm4_ff;
      end
   end

   // stage 6: full products
   logic [2*MW-1:0] hsq_in;
   logic [2*MW-1:0] ac_in;
   logic [2*MW-1:0] hsq_ff;
   logic [2*MW-1:0] ac_ff;
   logic            ok6_ff;
   logic [MW-1:0]   a6_ff;
   logic [MW-1:0]   hm6_ff;

   assign hsq_in = (2*MW)'(hh00_ff) + ((2*MW)'(hh01_ff) << (HW + 1))
                 + ((2*MW)'(hh11_ff) << (2*HW));
   assign ac_in  = (2*MW)'(ac00_ff) + (((2*MW)'(ac01_ff) + (2*MW)'(ac10_ff)) << HW)
                 + ((2*MW)'(ac11_ff) << (2*HW));

   always_ff @(posedge clock) begin
      if (adv) begin
         hsq_ff <= hsq_in;
         ac_ff  <= ac_in;
         ok6_ff <= ok5_ff;
         a6_ff  <= a5_ff;
         hm6_ff <= hm5_ff;
      end
   end

   // stage 7: quarter discriminant
   logic [2*MW:0]        disc_in;
   logic [2*MW-1:0]      disc_ff;
   sscol_pkg::side_type  side7_ff;

   assign disc_in = {1'b0, hsq_ff} - {1'b0, ac_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         disc_ff        <= disc_in[2*MW-1:0];
         side7_ff.ok    <= ok6_ff && !disc_in[2*MW];
         side7_ff.h_mag <= hm6_ff;
         side7_ff.a     <= a6_ff;
      end
   end

   // square root of disc * 2^(2T), rounded down, with an inexact flag
   logic                 sq_vld;
   logic [RootW-1:0]     sq_root;
   logic                 sq_inexact;
   sscol_pkg::side_type  sq_side;

   sscol_sqrt #(
      .RootW (RootW)
   ) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (pre_vld_ff[6]),
      .in_rad      ({disc_ff, {(2*TIME_FRAC_BITS){1'b0}}}),
      .in_side     (side7_ff),
      .out_valid   (sq_vld),
      .out_root    (sq_root),
      .out_inexact (sq_inexact),
      .out_side    (sq_side)
   );

   // numerator, with the root rounded up by the inexact flag, clamped at zero
   logic [RootW:0]       num_in;
   logic                 nm_vld_ff;
   logic [RootW-1:0]     nm_num_ff;
   sscol_pkg::side_type  nm_side_ff;

   assign num_in = {1'b0, sq_side.h_mag, {TIME_FRAC_BITS{1'b0}}} - {1'b0, sq_root}
                 - (RootW+1)'(sq_inexact);

   always_ff @(posedge clock) begin
      if (reset) begin
         nm_vld_ff <= 1'b0;
      end else if (adv) begin
         nm_vld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nm_num_ff  <= num_in[RootW] ? '0 : num_in[RootW-1:0];
         nm_side_ff <= sq_side;
      end
   end

   // restoring divider, one quotient bit per stage
   logic                 dv_vld_ff  [QuoW];
   logic [RootW-1:0]     dv_rem_ff  [QuoW];
   logic [QuoW-1:0]      dv_quo_ff  [QuoW];
   sscol_pkg::side_type  dv_side_ff [QuoW];

   for (genvar j = 0; j < QuoW; j++) begin : g_div
      logic                 vld_src;
      logic [RootW-1:0]     rem_src;
      logic [QuoW-1:0]      quo_src;
      sscol_pkg::side_type  side_src;
      logic [RootW-1:0]     dsh;
      logic                 fits;
      logic [RootW-1:0]     rem_in;
      logic [QuoW-1:0]      quo_in;

      if (j == 0) begin : g_first
         assign vld_src  = nm_vld_ff;
         assign rem_src  = nm_num_ff;
         assign quo_src  = '0;
         assign side_src = nm_side_ff;
      end else begin : g_next
         assign vld_src  = dv_vld_ff[j-1];
         assign rem_src  = dv_rem_ff[j-1];
         assign quo_src  = dv_quo_ff[j-1];
         assign side_src = dv_side_ff[j-1];
      end

      assign dsh    = {{TIME_FRAC_BITS{1'b0}}, side_src.a} << (QuoW - 1 - j);
      assign fits   = (rem_src >= dsh);
      assign rem_in = fits ? (rem_src - dsh) : rem_src;
      assign quo_in = {quo_src[QuoW-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[j] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[j]  <= rem_in;
            dv_quo_ff[j]  <= quo_in;
            dv_side_ff[j] <= side_src;
         end
      end
   end

   // output register
   logic              rsp_vld_ff;
   logic              hit_ff;
   logic [ImpW-1:0]   impact_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= dv_vld_ff[QuoW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff    <= dv_side_ff[QuoW-1].ok;
         impact_ff <= dv_side_ff[QuoW-1].ok ? ImpW'(dv_quo_ff[QuoW-1]) : '0;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = hit_ff;
   assign rsp_tdata  = {{(sscol_pkg::RSP_DATA_W - ImpW){1'b0}}, impact_ff};

   `SSCOL_ASSERT_IMPLY(a_miss_zero_time, clock, reset,
      rsp_tvalid && !rsp_tuser, rsp_tdata[ImpW-1:0] == '0)
   `SSCOL_ASSERT_IMPLY(a_time_in_step, clock, reset,
      rsp_tvalid && rsp_tuser,
      32'(rsp_tdata[ImpW-1:0]) <= (32'd1 << TIME_FRAC_BITS))
   `SSCOL_ASSERT_IMPLY(a_stall_blocks_input, clock, reset,
      rsp_tvalid && !rsp_tready, !req_tready)
   `SSCOL_ASSERT_NEXT(a_accept_enters, clock, reset,
      req_tvalid && req_tready, pre_vld_ff[0])

endmodule

/* dv/swept_sphere_collision_time_top_tb.sv */
// Self-checking testbench for swept_sphere_collision_time_top: a wide-integer
// predictor checks hit and impact time under several idle and stall mixes.
// Depends on sscol_pkg and the RTL of the block.
`timescale 1ns / 1ps

module swept_sphere_collision_time_top_tb;

   localparam int IDLE_LIMIT = 40000;
   localparam int DRAIN_CYCLES = 250;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic                                         prev_valid;
      logic [sscol_pkg::RADIUS_W-1:0]               other_radius;
      logic [sscol_pkg::RADIUS_W-1:0]               mover_radius;
      logic [8:0][sscol_pkg::COORD_W-1:0]           coord;   // prev xyz, cur xyz, other xyz
   } sweep_query_type;

   typedef struct packed {
      logic                              hit;
      logic [sscol_pkg::IMPACT_W-1:0]    impact_time;
   } contact_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [sscol_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [sscol_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;

   sweep_query_type pending_queries[$];
   contact_type expected_contacts[$];
   sweep_query_type query_on_bus;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_armed = 1'b1;
   int hold_left = 0;
   int errors = 0;
   int sent = 0;
   int received = 0;
   int hits_seen = 0;
   int quiet_cycles = 0;

   swept_sphere_collision_time_top i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic contact_type predict_contact(sweep_query_type q);
      logic signed [191:0] a, h, c, v, r, rs, disc, e, f, num;
      logic [191:0] sq_in, root, cand, quo;
      longint p, cu, o;
      contact_type res;
      res = '0;
      a = 0;
      h = 0;
      c = 0;
      if (!q.prev_valid) return res;
      for (int i = 0; i < 3; i++) begin
         p = longint'($signed(q.coord[i]));
         cu = longint'($signed(q.coord[3+i]));
         o = longint'($signed(q.coord[6+i]));
         v = cu - p;
         r = p - o;
         a = a + v * v;
         h = h + r * v;
         c = c + r * r;
      end
      rs = 0;
      rs = rs + q.mover_radius + q.other_radius;
      c = c - rs * rs;
      if (a < 192'sd4295) return res;
      disc = h * h - a * c;
      if (disc < 0 || c < 0 || h > 0) return res;
      e = -h - a;
      if (e > 0) begin
         f = a + h + h + c;
         if (f > 0) return res;
      end
      sq_in = disc << 32;
      root = '0;
      for (int b = 94; b >= 0; b--) begin
         cand = root | (192'(1) << b);
         if (cand * cand <= sq_in) root = cand;
      end
      if (root * root != sq_in) root = root + 1;
      num = ((-h) <<< 16) - $signed(root);
      if (num < 0) num = 0;
      quo = $unsigned(num) / $unsigned(a);
      res.hit = 1'b1;
      res.impact_time = quo[sscol_pkg::IMPACT_W-1:0];
      return res;
   endfunction

   function automatic int spread(int k);
      return int'($urandom_range(0, 2 * k)) - k;
   endfunction

   function automatic sweep_query_type random_query();
      sweep_query_type q;
      int k, sel;
      sel = $urandom_range(0, 99);
      q.prev_valid = 1'b1;
      if (sel < 10) begin
         for (int i = 0; i < 9; i++) q.coord[i] = $urandom();
         q.mover_radius = sscol_pkg::RADIUS_W'($urandom());
         q.other_radius = sscol_pkg::RADIUS_W'($urandom());
         q.prev_valid = 1'($urandom_range(0, 1));
         return q;
      end
      k = 1 << $urandom_range(2, 27);
      for (int i = 0; i < 3; i++) begin
         q.coord[6+i] = spread(k);
         q.coord[i] = $signed(q.coord[6+i]) + spread(k);
         q.coord[3+i] = $signed(q.coord[6+i]) + spread(k / 4);
      end
      q.mover_radius = sscol_pkg::RADIUS_W'($urandom_range(0, k / 2));
      q.other_radius = sscol_pkg::RADIUS_W'($urandom_range(0, k / 2));
      if (sel < 15) q.prev_valid = 1'b0;
      else if (sel < 20)
         for (int i = 0; i < 3; i++) q.coord[3+i] = q.coord[i] + $urandom_range(0, 1);
      else if (sel < 30)
         for (int i = 0; i < 3; i++) q.coord[3+i] = $signed(q.coord[i]) + spread(k);
      return q;
   endfunction

   function automatic sweep_query_type line_query(int px, int cx, int ox, int mr, int orad);
      sweep_query_type q;
      q = '0;
      q.prev_valid = 1'b1;
      q.coord[0] = px;
      q.coord[3] = cx;
      q.coord[6] = ox;
      q.mover_radius = sscol_pkg::RADIUS_W'(mr);
      q.other_radius = sscol_pkg::RADIUS_W'(orad);
      return q;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_contacts = {expected_contacts, predict_contact(query_on_bus)};
            sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_queries.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               query_on_bus = pending_queries.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {2'b00, query_on_bus.other_radius, query_on_bus.mover_radius,
                             query_on_bus.coord};
               req_tuser <= query_on_bus.prev_valid;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver backpressure, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_armed && sent >= 40) begin
         hold_armed <= 1'b0;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      contact_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         received++;
         if (expected_contacts.size() == 0) begin
            $display("%0t: unexpected result hit=%0b time=%0d", $time, rsp_tuser,
                     rsp_tdata[sscol_pkg::IMPACT_W-1:0]);
            errors++;
         end else begin
            want = expected_contacts.pop_front();
            if (want.hit !== rsp_tuser) begin
               $display("%0t: hit mismatch expected %0b actual %0b", $time, want.hit,
                        rsp_tuser);
               errors++;
            end
            if (want.impact_time !== rsp_tdata[sscol_pkg::IMPACT_W-1:0]) begin
               $display("%0t: impact_time mismatch expected %0d actual %0d", $time,
                        want.impact_time, rsp_tdata[sscol_pkg::IMPACT_W-1:0]);
               errors++;
            end
            if (want.hit) hits_seen++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("swept_sphere_collision_time_top_tb failed");
            $finish;
         end
      end
   end

   initial begin
      int idle_mix[4];
      int stall_mix[4];
      sweep_query_type q;
      idle_mix = '{0, 88, 0, 31};
      stall_mix = '{0, 0, 88, 31};

      // no previous position, zero motion, extremes
      q = line_query(0, 65536, 131072, 65536, 65536);
      q.prev_valid = 1'b0;
      pending_queries = {pending_queries, q};
      pending_queries = {pending_queries, line_query(-327680, -327680, 0, 65536, 65536)};
      pending_queries = {pending_queries, line_query(-327680, -327679, 0, 65536, 65536)};
      pending_queries = {pending_queries, line_query(-327680, 327680, 0, 65536, 65536)};
      pending_queries = {pending_queries, line_query(-262144, 0, 0, 65536, 65536)};
      pending_queries = {pending_queries, line_query(-131072, 0, 0, 65536, 65536)};
      pending_queries = {pending_queries, line_query(-524288, -262144, 0, 65536, 65536)};
      pending_queries = {pending_queries, line_query(0, 65536, 0, 65536, 65536)};
      pending_queries = {pending_queries, line_query(327680, 655360, 0, 65536, 65536)};
      q = line_query(-327680, 327680, 0, 65536, 65536);
      q.coord[1] = 32'sd300000;
      q.coord[4] = 32'sd300000;
      pending_queries = {pending_queries, q};
      pending_queries = {pending_queries, line_query(32'h8000_0000, 32'h7fff_ffff, 0, 0, 0)};
      pending_queries = {pending_queries,
                         line_query(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                                    32'h7fff_ffff, 32'h7fff_ffff)};
      q = '1;
      pending_queries = {pending_queries, q};
      q = '0;
      q.prev_valid = 1'b1;
      for (int i = 0; i < 9; i++) q.coord[i] = (i < 3 || i >= 6) ? 32'h8000_0000 : 32'h7fff_ffff;
      q.mover_radius = '1;
      pending_queries = {pending_queries, q};
      for (int i = 0; i < 9; i++) q.coord[i] = (i < 3) ? 32'h7fff_ffff : 32'h8000_0000;
      q.other_radius = '1;
      pending_queries = {pending_queries, q};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_mix[ph];
         recv_stall_pct = stall_mix[ph];
         for (int n = 0; n < 210; n++) pending_queries = {pending_queries, random_query()};
         while (pending_queries.size() > 0 || req_tvalid) @(posedge clock);
      end
      recv_stall_pct = 0;
      while (expected_contacts.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d queries and %0d results, %0d of them hits,", sent, received,
               hits_seen);
      $display("over idle-free, sender-idle, receiver-stall and mixed phases");
      if (errors == 0 && expected_contacts.size() == 0) begin
         $display("swept_sphere_collision_time_top_tb passed");
      end else begin
         $display("swept_sphere_collision_time_top_tb failed");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+src
src/sscol_pkg.sv
src/sscol_sqrt.sv
src/swept_sphere_collision_time_top.sv
dv/swept_sphere_collision_time_top_tb.sv
